### src/plir_pkg.sv
// ----------------------------------------------------------------------------
// plir_pkg
// Shared types and constants for the positional list insert/remove block.
// ----------------------------------------------------------------------------
package plir_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  // compare width covers both cell indexes and the 7-bit position field
  localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic               shift;
    logic               insert;
    logic [CMP_W-1:0]   pos_idx;
    logic [DATA_W-1:0]  value;
  } cell_cmd_t;

  // outcome of one transaction as decided by the controller
  typedef struct packed {
    status_t            status;
    logic               remove;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   len_nxt;
  } ctrl_res_t;

endpackage

### src/plir_if.sv
// ----------------------------------------------------------------------------
// plir_if
// Valid/ready channels for list commands and list results.
// ----------------------------------------------------------------------------
interface plir_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [plir_pkg::POS_W-1:0]      position;
  logic signed [plir_pkg::DATA_W-1:0] value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface plir_out_if;
  logic                               valid;
  logic                               ready;
  logic [plir_pkg::STAT_W-1:0]        status;
  logic signed [plir_pkg::DATA_W-1:0] removed_value;
  logic [plir_pkg::POS_W-1:0]         list_length;

  modport source (output valid, status, removed_value, list_length, input ready);
  modport sink   (input valid, status, removed_value, list_length, output ready);
endinterface

### src/plir_cell.sv
// ----------------------------------------------------------------------------
// plir_cell
// One list slot: holds a value and takes its neighbor's, or the inserted value, on a shift.
// ----------------------------------------------------------------------------
module plir_cell (
  input  logic                          clk,
  input  plir_pkg::cell_cmd_t           cmd,
  input  logic [plir_pkg::IDX_W-1:0]    idx,
  input  logic [plir_pkg::DATA_W-1:0]   prev_data,
  input  logic [plir_pkg::DATA_W-1:0]   next_data,
  output logic [plir_pkg::DATA_W-1:0]   data
);

  logic [plir_pkg::DATA_W-1:0] data_r;
  logic [plir_pkg::DATA_W-1:0] data_nxt;
  logic [plir_pkg::CMP_W-1:0]  idx_ext;

  assign idx_ext = plir_pkg::CMP_W'(idx);

  always_comb begin
    data_nxt = data_r;
    if (cmd.shift) begin
      if (cmd.insert) begin
        if (idx_ext == cmd.pos_idx) begin
          data_nxt = cmd.value;
        end else if (idx_ext > cmd.pos_idx) begin
          data_nxt = prev_data;
        end
      end else if (idx_ext >= cmd.pos_idx) begin
        data_nxt = next_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

### src/plir_ctrl.sv
// ----------------------------------------------------------------------------
// plir_ctrl
// Length counter and position checks; drives the cell row command.
// ----------------------------------------------------------------------------
module plir_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          opcode,
  input  logic [plir_pkg::POS_W-1:0]    position,
  input  logic [plir_pkg::DATA_W-1:0]   value,
  output plir_pkg::cell_cmd_t           cmd,
  output plir_pkg::ctrl_res_t           res
);

  logic [plir_pkg::LEN_W-1:0] len_r;
  logic [plir_pkg::LEN_W-1:0] len_nxt;
  logic [plir_pkg::CMP_W-1:0] pos_ext;
  logic [plir_pkg::CMP_W-1:0] len_ext;
  logic [plir_pkg::CMP_W-1:0] pos_idx;
  logic                       pos_zero;
  logic                       ins_ok;
  logic                       rem_ok;
  logic                       full;
  plir_pkg::status_t          status;

  assign pos_ext  = plir_pkg::CMP_W'(position);
  assign len_ext  = plir_pkg::CMP_W'(len_r);
  assign pos_idx  = pos_ext - plir_pkg::CMP_W'(1);
  assign pos_zero = (position == '0);
  // insert is legal up to one past the end
  assign ins_ok   = !pos_zero && ({1'b0, pos_ext} <= ({1'b0, len_ext} + (plir_pkg::CMP_W+1)'(1)));
  assign rem_ok   = !pos_zero && (pos_ext <= len_ext);
  assign full     = (len_r == plir_pkg::LEN_W'(plir_pkg::CAPACITY));

  always_comb begin
    status  = plir_pkg::ST_DONE;
    len_nxt = len_r;
    if (opcode == plir_pkg::OP_INSERT) begin
      if (!ins_ok) begin
        status = plir_pkg::ST_BADPOS;
      end else if (full) begin
        status = plir_pkg::ST_FULL;
      end else begin
        len_nxt = len_r + plir_pkg::LEN_W'(1);
      end
    end else begin
      if (!rem_ok) begin
        status = plir_pkg::ST_BADPOS;
      end else begin
        len_nxt = len_r - plir_pkg::LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (accept) begin
      len_r <= len_nxt;
    end
  end

  assign cmd.shift   = accept && (status == plir_pkg::ST_DONE);
  assign cmd.insert  = (opcode == plir_pkg::OP_INSERT);
  assign cmd.pos_idx = pos_idx;
  assign cmd.value   = value;

  assign res.status  = status;
  assign res.remove  = (opcode == plir_pkg::OP_REMOVE);
  assign res.len     = len_r;
  assign res.len_nxt = len_nxt;

endmodule

### src/positional_list_insert_remove.sv
// ----------------------------------------------------------------------------
// positional_list_insert_remove
// Ordered list of signed values with insert and remove at a 1-based position.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one value per cell. An accepted
// insert or remove shifts the cells from its position onward by one place
// in the cycle it is accepted. A command is taken every clock cycle unless
// a stalled result fills the output register, and then only once it frees
// up; each result reaches the output register in the next cycle. The list
// is empty after reset. Status reports done, illegal position or list full;
// the length after the command is reported modulo 128.
module positional_list_insert_remove (
  input  logic       clk,
  input  logic       rst_n,
  plir_in_if.sink    in_ch,
  plir_out_if.source out_ch
);

  logic                           in_acc;
  logic                           out_valid_r;
  logic [plir_pkg::STAT_W-1:0]    out_status_r;
  logic [plir_pkg::DATA_W-1:0]    out_removed_r;
  logic [plir_pkg::POS_W-1:0]     out_len_r;
  logic [plir_pkg::DATA_W-1:0]    removed_nxt;
  logic [plir_pkg::CMP_W-1:0]     len_nxt_ext;
  logic [plir_pkg::DATA_W-1:0]    cell_data [plir_pkg::CAPACITY];
  plir_pkg::cell_cmd_t            cmd;
  plir_pkg::ctrl_res_t            res;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  plir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .opcode   (in_ch.opcode),
    .position (in_ch.position),
    .value    (in_ch.value),
    .cmd      (cmd),
    .res      (res)
  );

  for (genvar i = 0; i < plir_pkg::CAPACITY; i++) begin : g_cell
    logic [plir_pkg::DATA_W-1:0] prev_d;
    logic [plir_pkg::DATA_W-1:0] next_d;

    if (i == 0) begin : g_first
      assign prev_d = cmd.value;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end
    if (i == plir_pkg::CAPACITY - 1) begin : g_last
      assign next_d = cell_data[i];
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
    end

    plir_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (plir_pkg::IDX_W'(i)),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i])
    );
  end

  // value leaving the row on a successful remove
  always_comb begin
    removed_nxt = '0;
    if (res.remove && (res.status == plir_pkg::ST_DONE)) begin
      removed_nxt = cell_data[cmd.pos_idx[plir_pkg::IDX_W-1:0]];
    end
  end

  assign len_nxt_ext = plir_pkg::CMP_W'(res.len_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r  <= res.status;
      out_removed_r <= removed_nxt;
      out_len_r     <= len_nxt_ext[plir_pkg::POS_W-1:0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.list_length   = out_len_r;

  // length never passes the row size
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res.len <= plir_pkg::LEN_W'(plir_pkg::CAPACITY))
    else $error("list length beyond capacity");

  // a failed transaction leaves the length alone
  a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (res.status != plir_pkg::ST_DONE)) |=> $stable(res.len))
    else $error("length changed on failed transaction");

  // a successful insert grows the list by one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !res.remove && (res.status == plir_pkg::ST_DONE))
      |=> (res.len == $past(res.len) + plir_pkg::LEN_W'(1)))
    else $error("insert did not grow the list");

  // only a successful remove reports a nonzero value
  a_rem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != plir_pkg::ST_DONE)) |-> (out_removed_r == '0))
    else $error("removed value on failed transaction");

endmodule
